@@ src/mld_pkg.sv @@
// Shared types and constants for the motion light dimmer.
// Holds the mode and opcode types, the register indexes, the reset values and the register set struct.
// No dependencies.
package mld_pkg;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_ON     = 2'd1,
		MODE_MANUAL = 2'd2
	} mode_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_APPLY = 1'b1
	} opcode_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_DIM_MAX        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_MIN        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ON_DURATION_MS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MANUAL_SELECT  = 3'd4;

	localparam logic [7:0]  RST_DIM_MAX        = 8'd255;
	localparam logic [7:0]  RST_DIM_MIN        = 8'd50;
	localparam logic [7:0]  RST_RAMP_STEPS     = 8'd5;
	localparam logic [31:0] RST_ON_DURATION_MS = 32'd30000;

	typedef struct packed {
		logic [7:0]  dim_max;
		logic [7:0]  dim_min;
		logic [7:0]  ramp_steps;
		logic [31:0] on_duration_ms;
		logic        manual_select;
	} cfg_t;

endpackage

@@ src/mld_ramp.sv @@
// Closed-form level ramp for one tick of the motion light dimmer.
// Depends on mld_pkg for the mode type and the register set struct.
module mld_ramp
	import mld_pkg::*;
(
	input  logic [7:0] level,
	input  logic [7:0] target,
	input  mode_t      mode,
	input  cfg_t       cfg,
	output logic [7:0] level_next
);

	logic [8:0] steps;
	logic       below;
	logic [7:0] lvl_start;
	logic [8:0] steps_left;
	logic [7:0] floor_tgt;
	logic [9:0] up_sum;
	logic [9:0] down_lim;
	logic [7:0] off_level;
	logic [7:0] on_level;

	// Zero steps means a full 256-unit sweep.
	assign steps = (cfg.ramp_steps == 8'd0) ? 9'd256 : {1'b0, cfg.ramp_steps};

	// Off mode always runs with target zero: step down, and once a step would
	// take the level under the floor it drops straight to zero.
	assign off_level = ({2'b00, level} >= ({1'b0, steps} + {2'b00, cfg.dim_min})) ?
		level - steps[7:0] : 8'd0;

	// Other modes: a level under the floor lifts to the floor on the first
	// step, and the floor also bounds the effective target.
	assign below      = level < cfg.dim_min;
	assign lvl_start  = below ? cfg.dim_min : level;
	assign steps_left = below ? steps - 9'd1 : steps;
	assign floor_tgt  = (target < cfg.dim_min) ? cfg.dim_min : target;
	assign up_sum     = {2'b00, lvl_start} + {1'b0, steps_left};
	assign down_lim   = {1'b0, steps_left} + {2'b00, floor_tgt};

	always_comb begin
		if (lvl_start < floor_tgt) begin
			on_level = (up_sum > {2'b00, floor_tgt}) ? floor_tgt : up_sum[7:0];
		end else if (lvl_start > floor_tgt) begin
			on_level = ({2'b00, lvl_start} < down_lim) ? floor_tgt :
				lvl_start - steps_left[7:0];
		end else begin
			on_level = lvl_start;
		end
	end

	assign level_next = (mode == MODE_OFF) ? off_level : on_level;

endmodule

@@ src/motion_light_dimmer.sv @@
// Top level of the motion light dimmer: register set, input stage, state and result stage.
// Depends on mld_pkg and on mld_ramp for the per-tick level ramp.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per item: opcode, motion
//   and now_ms. A tick word ramps the level toward the target and then handles the
//   motion sample and the no-motion timeout; an apply word enters on or manual
//   mode and sets the target to dim_max.
//   Output channel (out_valid / out_stall) returns exactly one result word per
//   input word, in order: dim_out, light_mode, report_valid, report_motion.
//   A word accepted at one clock edge is registered in the input stage, worked in
//   a single pass by the ramp and timeout logic, and its result is registered in the
//   result stage once that stage is free. One word per cycle is taken sustained while the output does not stall.
//   When the receiver stalls, the result word holds; the input register still
//   drains into it once the output is taken, and in_stall rises only while both
//   the input register and the output register are full.
//   Registers are written through cfg_we / cfg_index / cfg_wdata; the user must do so only
//   while no word is in flight, which the block does not enforce; indexes past the register list are ignored.
//   Reset (arst_n low) restores the register defaults, level 50, target 255,
//   on mode, last motion time zero and motion report off, and empties both stages.
module motion_light_dimmer
	import mld_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic                  motion,
	input  logic [31:0]           now_ms,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            dim_out,
	output logic [1:0]            light_mode,
	output logic                  report_valid,
	output logic                  report_motion,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t        cfg_q;

	// Input stage
	logic        valid_s1;
	opcode_t     opcode_s1;
	logic        motion_s1;
	logic [31:0] now_s1;

	// Dimmer state
	logic [7:0]  level_q;
	logic [7:0]  target_q;
	mode_t       mode_q;
	logic [31:0] last_motion_q;
	logic        reported_q;

	// Result stage
	logic        valid_s2;
	logic [7:0]  dim_s2;
	mode_t       mode_s2;
	logic        rep_valid_s2;
	logic        rep_motion_s2;

	logic        advance;
	logic        take_in;
	logic        step;

	logic [7:0]  ramp_level;
	logic [31:0] idle_ms;
	logic        timed_out;

	logic [7:0]  level_n;
	logic [7:0]  target_n;
	mode_t       mode_n;
	logic [31:0] last_motion_n;
	logic        reported_n;
	logic        rep_valid_n;
	logic [7:0]  shown_n;

	// Handshake: the result stage frees when empty or taken this cycle.
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;
	assign step     = valid_s1 && advance;

	// Register set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dim_max        <= RST_DIM_MAX;
			cfg_q.dim_min        <= RST_DIM_MIN;
			cfg_q.ramp_steps     <= RST_RAMP_STEPS;
			cfg_q.on_duration_ms <= RST_ON_DURATION_MS;
			cfg_q.manual_select  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIM_MAX:        cfg_q.dim_max        <= cfg_wdata[7:0];
				REG_DIM_MIN:        cfg_q.dim_min        <= cfg_wdata[7:0];
				REG_RAMP_STEPS:     cfg_q.ramp_steps     <= cfg_wdata[7:0];
				REG_ON_DURATION_MS: cfg_q.on_duration_ms <= cfg_wdata[31:0];
				REG_MANUAL_SELECT:  cfg_q.manual_select  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Capture the input word; hold it while the result stage is blocked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			opcode_s1 <= opcode_t'(opcode);
			motion_s1 <= motion;
			now_s1    <= now_ms;
		end
	end

	mld_ramp u_ramp (
		.level      (level_q),
		.target     (target_q),
		.mode       (mode_q),
		.cfg        (cfg_q),
		.level_next (ramp_level)
	);

	// Wrapping elapsed time since the last motion; strictly greater times out.
	assign idle_ms   = now_s1 - last_motion_q;
	assign timed_out = idle_ms > cfg_q.on_duration_ms;

	always_comb begin
		level_n       = level_q;
		target_n      = target_q;
		mode_n        = mode_q;
		last_motion_n = last_motion_q;
		reported_n    = reported_q;
		rep_valid_n   = 1'b0;
		shown_n       = level_q;
		case (opcode_s1)
			OP_APPLY: begin
				mode_n   = cfg_q.manual_select ? MODE_MANUAL : MODE_ON;
				target_n = cfg_q.dim_max;
			end
			OP_TICK: begin
				level_n = ramp_level;
				shown_n = ramp_level;
				if (motion_s1) begin
					// Movement: refresh the timestamp and wake an off light.
					rep_valid_n   = !reported_q;
					reported_n    = 1'b1;
					last_motion_n = now_s1;
					if (mode_q == MODE_OFF) begin
						mode_n   = MODE_ON;
						target_n = cfg_q.dim_max;
					end
				end else begin
					rep_valid_n = reported_q;
					reported_n  = 1'b0;
					if (mode_q == MODE_ON && timed_out) begin
						mode_n   = MODE_OFF;
						target_n = 8'd0;
					end
				end
			end
			default: ;
		endcase
	end

	// Advance the dimmer state once per worked word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q       <= RST_DIM_MIN;
			target_q      <= RST_DIM_MAX;
			mode_q        <= MODE_ON;
			last_motion_q <= 32'd0;
			reported_q    <= 1'b0;
		end else if (step) begin
			level_q       <= level_n;
			target_q      <= target_n;
			mode_q        <= mode_n;
			last_motion_q <= last_motion_n;
			reported_q    <= reported_n;
		end
	end

	// Result stage: load on a worked word, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			dim_s2        <= shown_n;
			mode_s2       <= mode_n;
			rep_valid_s2  <= rep_valid_n;
			rep_motion_s2 <= reported_n;
		end
	end

	assign out_valid     = valid_s2;
	assign dim_out       = dim_s2;
	assign light_mode    = mode_s2;
	assign report_valid  = rep_valid_s2;
	assign report_motion = rep_motion_s2;

`ifndef SYNTHESIS
	// The ramp relies on off mode always carrying a zero target.
	a_off_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_OFF |-> target_q == 8'd0)
		else $error("off mode with nonzero target");

	// A worked word always lands in the result stage.
	a_step_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("worked word lost before result stage");

	// An apply word never flags a report change.
	a_apply_no_report: assert property (@(posedge clk) disable iff (!arst_n)
		step && opcode_s1 == OP_APPLY |=> !report_valid)
		else $error("apply word flagged a report change");

	// Input back-pressure only when both stages are full and the output stalls.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a full pipeline");
`endif

endmodule
